### hw/rtl/ntw_pkg.sv
// Shared types, token codes and helper functions for the number-to-words block.
// No dependencies; imported by every module of the block.
package ntw_pkg;

    // Field widths
    localparam int VALUE_W  = 31;
    localparam int TOK_W    = 5;
    localparam int DIGIT_W  = 4;
    localparam int NUM_DIG  = 10;
    localparam int BCD_W    = NUM_DIG * DIGIT_W;

    // Converter: first bit at load, two bits per cycle for the rest
    localparam int SHIFT_W  = VALUE_W - 1;
    localparam int ITERS    = SHIFT_W / 2;
    localparam int CNT_W    = $clog2(ITERS);

    // Token slots: four groups (billion first), five phases each
    localparam int PHASES    = 5;
    localparam int NUM_GRP   = 4;
    localparam int SLOTS     = NUM_GRP * PHASES;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ZERO_SLOT = 3 * PHASES + 2;

    typedef logic [TOK_W-1:0] token_t;

    // Word codes
    localparam token_t TOK_ZERO      = 5'd0;
    localparam token_t TOK_TEN       = 5'd10;
    localparam token_t TOK_TENS_BASE = 5'd18;
    localparam token_t TOK_HUNDRED   = 5'd28;
    localparam token_t TOK_THOUSAND  = 5'd29;
    localparam token_t TOK_MILLION   = 5'd30;
    localparam token_t TOK_BILLION   = 5'd31;

    typedef struct packed {
        logic   [PHASES-1:0] mask;
        token_t [PHASES-1:0] tok;
    } group_t;

    // One classified number: which slots speak, and what they say
    typedef struct packed {
        logic   [SLOTS-1:0] mask;
        token_t [SLOTS-1:0] tok;
    } entry_t;

    // Add 3 to every BCD digit of 5 or more (one double-dabble adjust)
    function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int k = 0; k < NUM_DIG; k++) begin
            if (b[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                r[k*DIGIT_W +: DIGIT_W] = b[k*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return r;
    endfunction

    // Spell one group of three digits into its five phase slots:
    // hundreds digit, Hundred, teen/tens word, ones word, scale word
    function automatic group_t spell_group(input logic [DIGIT_W-1:0] h,
                                           input logic [DIGIT_W-1:0] t,
                                           input logic [DIGIT_W-1:0] o,
                                           input logic               is_units,
                                           input token_t             scale);
        group_t g;
        logic   nz;
        g  = '0;
        nz = (h != 4'd0) || (t != 4'd0) || (o != 4'd0);
        g.tok[0]  = {1'b0, h};
        g.mask[0] = (h != 4'd0);
        g.tok[1]  = TOK_HUNDRED;
        g.mask[1] = (h != 4'd0);
        if (t >= 4'd2) begin
            g.tok[2]  = TOK_TENS_BASE + {1'b0, t};
            g.mask[2] = 1'b1;
            g.tok[3]  = {1'b0, o};
            g.mask[3] = (o != 4'd0);
        end
        else begin
            g.tok[2]  = (t == 4'd1) ? (TOK_TEN + {1'b0, o}) : {1'b0, o};
            g.mask[2] = (t != 4'd0) || (o != 4'd0);
        end
        g.tok[4]  = scale;
        g.mask[4] = nz && !is_units;
        return g;
    endfunction

endpackage

### hw/rtl/ntw_front.sv
// Front end: accepts a number, converts it to BCD and classifies it into token slots.
// Depends on ntw_pkg.
module ntw_front
    import ntw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output entry_t             out_entry
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;

    logic               accept;
    logic               push;
    logic [BCD_W-1:0]   adj1;
    logic [BCD_W-1:0]   adj2;
    logic [BCD_W-1:0]   step1;
    logic [BCD_W-1:0]   step2;
    group_t             grp [NUM_GRP];

    assign push      = done_reg && out_ready;
    assign in_ready  = !busy_reg && (!done_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = done_reg;

    // Two double-dabble steps per cycle
    always_comb
    begin
        adj1  = dabble_adjust(bcd_reg);
        step1 = {adj1[BCD_W-2:0], shift_reg[SHIFT_W-1]};
        adj2  = dabble_adjust(step1);
        step2 = {adj2[BCD_W-2:0], shift_reg[SHIFT_W-2]};
    end

    // Sequence the conversion
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (push) begin
            done_next = 1'b0;
        end
        if (accept) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = in_value[SHIFT_W-1:0];
            bcd_next   = {{(BCD_W-1){1'b0}}, in_value[VALUE_W-1]};
        end
        else if (busy_reg) begin
            shift_next = {shift_reg[SHIFT_W-3:0], 2'b00};
            bcd_next   = step2;
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ITERS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    // Classify the digits into slots, billion group lowest
    always_comb
    begin
        grp[0] = spell_group(4'd0, 4'd0, bcd_reg[39:36], 1'b0, TOK_BILLION);
        grp[1] = spell_group(bcd_reg[35:32], bcd_reg[31:28], bcd_reg[27:24],
                             1'b0, TOK_MILLION);
        grp[2] = spell_group(bcd_reg[23:20], bcd_reg[19:16], bcd_reg[15:12],
                             1'b0, TOK_THOUSAND);
        grp[3] = spell_group(bcd_reg[11:8], bcd_reg[7:4], bcd_reg[3:0],
                             1'b1, TOK_ZERO);
        for (int g = 0; g < NUM_GRP; g++) begin
            out_entry.mask[g*PHASES +: PHASES] = grp[g].mask;
            out_entry.tok[g*PHASES +: PHASES]  = grp[g].tok;
        end
        // A zero number speaks the single word Zero from the units slot
        if (bcd_reg == '0) begin
            out_entry.mask[ZERO_SLOT] = 1'b1;
        end
    end

    a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("front converting while a result is still held");

endmodule

### hw/rtl/ntw_queue.sv
// Two-entry queue of classified numbers between front and back.
// Depends on ntw_pkg.
module ntw_queue
    import ntw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  entry_t in_entry,
    output logic   out_valid,
    input  logic   out_ready,
    output entry_t out_entry
);

    localparam int DEPTH = 2;

    entry_t      slot_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_entry = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

### hw/rtl/ntw_back.sv
// Back end: walks a number's slot mask, sending one word per cycle while out_ready.
// Depends on ntw_pkg.
module ntw_back
    import ntw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  entry_t in_entry,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_word,
    output logic   out_last
);

    logic   [SLOTS-1:0] mask_reg, mask_next;
    token_t [SLOTS-1:0] tok_reg;
    logic   [SLOT_W-1:0] cur;
    logic                out_fire;
    logic                load;

    // Pick the lowest pending slot
    always_comb
    begin
        cur = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                cur = SLOT_W'(i);
            end
        end
    end

    assign out_valid = (mask_reg != '0);
    assign out_last  = ((mask_reg & (mask_reg - SLOTS'(1))) == '0);
    assign out_word  = tok_reg[cur];
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = !out_valid || (out_fire && out_last);
    assign load      = in_valid && in_ready;

    // Drop the sent slot, or take the next number
    always_comb
    begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = in_entry.mask;
        end
        else if (out_fire) begin
            mask_next = mask_reg & (mask_reg - SLOTS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg <= '0;
        end
        else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            tok_reg <= in_entry.tok;
        end
    end

    a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word == TOK_ZERO) |-> out_last)
        else $error("Zero word sent inside a longer run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !out_last) |=> out_valid)
        else $error("run ended without a last word");

endmodule

### hw/rtl/number_to_word_tokens.sv
// Top level of the number-to-words block: front converter, queue, word sender.
// Depends on ntw_pkg, ntw_front, ntw_queue and ntw_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tdata[30:0] value
//  m       | out | m_tvalid/m_tready  | m_tdata[4:0] word, m_tlast last
//
// In the front, one bit of a number is loaded and the other 30 go through the
// binary-to-decimal shifter two bits per cycle. The back sends one word per cycle
// with m_tready high, 1 to 16 words per number, while the front converts the next.
// A two-entry queue decouples the two, so either side may stall on its own.
// Reset (rst_n, asynchronous, active low) empties the converter, queue and sender.
module number_to_word_tokens
    import ntw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value, [31] zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [4:0] word, [7:5] zero fill
    output logic        m_tlast
);

    logic   f_valid;
    logic   f_ready;
    entry_t f_entry;
    logic   q_valid;
    logic   q_ready;
    entry_t q_entry;
    token_t word;

    ntw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_entry (f_entry)
    );

    ntw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_entry  (f_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    ntw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_entry  (q_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (word),
        .out_last  (m_tlast)
    );

    // Pack the word into the byte-wide data bus
    assign m_tdata = {3'b000, word};

endmodule
